>>> src/rbc_pkg.sv
package rbc_pkg;

  localparam int NUM_RES   = 6;
  localparam int CNT_W     = 64;
  localparam int CODE_W    = 3;
  localparam int SLOT_W    = $clog2(NUM_RES);
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] USAGE_MAX = '1;

  typedef enum logic [CODE_W-1:0] {
    RES_NONE       = 3'd0,
    RES_FUEL       = 3'd1,
    RES_CALL_DEPTH = 3'd2,
    RES_HEAP       = 3'd3,
    RES_AGGREGATE  = 3'd4,
    RES_GEN_DECL   = 3'd5,
    RES_DIAG       = 3'd6,
    RES_INVALID    = 3'd7
  } res_code_t;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;
  } cfg_wr_t;

  // True for the six codes that own a counter
  function automatic logic is_budgeted(logic [CODE_W-1:0] code);
    return (code != RES_NONE) && (code != RES_INVALID);
  endfunction

  // Map a resource code to its counter slot; unbudgeted codes map to slot zero
  function automatic logic [SLOT_W-1:0] code_to_slot(logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] dec;
    dec = code - CODE_W'(1);
    return is_budgeted(code) ? SLOT_W'(dec) : '0;
  endfunction

endpackage

>>> src/rbc_usage_mem.sv
module rbc_usage_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [rbc_pkg::SLOT_W-1:0]    rd_addr,
  input  rbc_pkg::mem_wr_t              wr,
  output logic [rbc_pkg::CNT_W-1:0]     rd_data
);

  logic [rbc_pkg::CNT_W-1:0]   mem [rbc_pkg::NUM_RES];
  logic [rbc_pkg::NUM_RES-1:0] valid_r;
  logic [rbc_pkg::CNT_W-1:0]   rd_data_r;
  logic                        rd_valid_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Track written entries; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

>>> src/rbc_limit_bank.sv
module rbc_limit_bank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbc_pkg::cfg_wr_t              cfg_wr,
  input  logic [rbc_pkg::SLOT_W-1:0]    rd_slot,
  output logic [rbc_pkg::CNT_W-1:0]     rd_limit
);

  logic [rbc_pkg::CNT_W-1:0] lim_r [rbc_pkg::NUM_RES];

  // Take register writes; drop indexes beyond the last resource
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rbc_pkg::NUM_RES; i++) begin
        lim_r[i] <= '0;
      end
    end else if (cfg_wr.en &&
                 (cfg_wr.index < rbc_pkg::CFG_IDX_W'(rbc_pkg::NUM_RES))) begin
      lim_r[rbc_pkg::SLOT_W'(cfg_wr.index)] <= cfg_wr.data;
    end
  end

  // Select the limit of the active slot
  assign rd_limit = (rd_slot < rbc_pkg::SLOT_W'(rbc_pkg::NUM_RES)) ? lim_r[rd_slot] : '0;

endmodule

>>> src/resource_budget_consume_top.sv
// Flow: the request and the usage memory read are registered at the input transfer,
// then the compute state does the add, limit compare and write-back of the same entry
// and loads the output register once it is empty or draining; no new input is taken meanwhile.
// A waiting result does not block the next input transfer.
// Reset: synchronous active low; limits, exceed record and counter valid
// bits clear together, no clearing pass.
module resource_budget_consume_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rbc_pkg::CODE_W-1:0]       in_resource,
  input  logic [rbc_pkg::CNT_W-1:0]        in_amount,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_granted,
  output logic [rbc_pkg::CNT_W-1:0]        out_new_usage,
  output logic [rbc_pkg::CODE_W-1:0]       out_exceeded_code,
  output logic [rbc_pkg::CNT_W-1:0]        out_exceeded_limit_value,
  output logic [rbc_pkg::CNT_W-1:0]        out_exceeded_request,
  input  logic                             cfg_we,
  input  logic [rbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbc_pkg::CNT_W-1:0]        cfg_wdata
);

  rbc_pkg::state_t state_r, state_nxt;

  logic                         in_xfer;
  logic                         load_w;
  logic                         exceed_w;
  logic                         budgeted_w;
  logic [rbc_pkg::SLOT_W-1:0]   slot_r;
  logic [rbc_pkg::CODE_W-1:0]   code_r;
  logic [rbc_pkg::CNT_W-1:0]    amount_r;
  logic [rbc_pkg::CNT_W-1:0]    used_w;
  logic [rbc_pkg::CNT_W-1:0]    lim_w;
  logic [rbc_pkg::CNT_W:0]      sum_w;
  logic [rbc_pkg::CNT_W-1:0]    wanted_w;
  logic [rbc_pkg::CNT_W-1:0]    shown_w;

  logic [rbc_pkg::CODE_W-1:0]   exc_code_r, exc_code_nxt;
  logic [rbc_pkg::CNT_W-1:0]    exc_limit_r, exc_limit_nxt;
  logic [rbc_pkg::CNT_W-1:0]    exc_req_r, exc_req_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_granted_r;
  logic [rbc_pkg::CNT_W-1:0]    out_new_usage_r;
  logic [rbc_pkg::CODE_W-1:0]   out_exc_code_r;
  logic [rbc_pkg::CNT_W-1:0]    out_exc_limit_r;
  logic [rbc_pkg::CNT_W-1:0]    out_exc_req_r;

  rbc_pkg::mem_wr_t mem_wr;
  rbc_pkg::cfg_wr_t cfg_wr;

  assign in_xfer = in_valid && in_ready;

  assign cfg_wr.en    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_wdata;

  rbc_usage_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_xfer),
    .rd_addr (rbc_pkg::code_to_slot(in_resource)),
    .wr      (mem_wr),
    .rd_data (used_w)
  );

  rbc_limit_bank u_lim (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .rd_slot  (slot_r),
    .rd_limit (lim_w)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rbc_pkg::S_IDLE: if (in_xfer) state_nxt = rbc_pkg::S_CALC;
      rbc_pkg::S_CALC: if (load_w)  state_nxt = rbc_pkg::S_IDLE;
      default:         state_nxt = rbc_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    load_w   = 1'b0;
    unique case (state_r)
      rbc_pkg::S_IDLE: in_ready = 1'b1;
      rbc_pkg::S_CALC: load_w   = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        load_w   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      code_r   <= in_resource;
      slot_r   <= rbc_pkg::code_to_slot(in_resource);
      amount_r <= in_amount;
    end
  end

  // Add without wrap, compare against limit, saturate the request
  assign budgeted_w = rbc_pkg::is_budgeted(code_r);
  assign sum_w      = {1'b0, used_w} + {1'b0, amount_r};
  assign exceed_w   = sum_w > {1'b0, lim_w};
  assign wanted_w   = sum_w[rbc_pkg::CNT_W] ? rbc_pkg::USAGE_MAX : sum_w[rbc_pkg::CNT_W-1:0];
  assign shown_w    = !budgeted_w ? '0 : (exceed_w ? used_w : wanted_w);

  // Write back a granted counter
  assign mem_wr.en   = load_w && budgeted_w && !exceed_w;
  assign mem_wr.addr = slot_r;
  assign mem_wr.data = wanted_w;

  // Update the exceed record on a refused budgeted request
  always_comb begin
    exc_code_nxt  = exc_code_r;
    exc_limit_nxt = exc_limit_r;
    exc_req_nxt   = exc_req_r;
    if (budgeted_w && exceed_w) begin
      exc_code_nxt  = code_r;
      exc_limit_nxt = lim_w;
      exc_req_nxt   = wanted_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exc_code_r  <= '0;
      exc_limit_r <= '0;
      exc_req_r   <= '0;
    end else if (load_w) begin
      exc_code_r  <= exc_code_nxt;
      exc_limit_r <= exc_limit_nxt;
      exc_req_r   <= exc_req_nxt;
    end
  end

  // Output register: hold until transfer
  assign out_valid_nxt = load_w ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_w) begin
      out_granted_r   <= budgeted_w && !exceed_w;
      out_new_usage_r <= shown_w;
      out_exc_code_r  <= exc_code_nxt;
      out_exc_limit_r <= exc_limit_nxt;
      out_exc_req_r   <= exc_req_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_granted              = out_granted_r;
  assign out_new_usage            = out_new_usage_r;
  assign out_exceeded_code        = out_exc_code_r;
  assign out_exceeded_limit_value = out_exc_limit_r;
  assign out_exceeded_request     = out_exc_req_r;

  // A new result only comes out of the compute state
  a_rise_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == rbc_pkg::S_CALC)
    else $error("result appeared without a compute cycle");

  // No counter write-back while waiting for a request
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rbc_pkg::S_IDLE |-> !mem_wr.en)
    else $error("usage memory written while idle");

  // A grant leaves the exceed record alone
  a_grant_keeps_record: assert property (@(posedge clk) disable iff (!rst_n)
    (load_w && !exceed_w) |=> $stable(exc_code_r) && $stable(exc_limit_r)
                              && $stable(exc_req_r))
    else $error("exceed record changed on a grant");

  // A granted usage covers at least the amount just added
  a_grant_covers_amount: assert property (@(posedge clk) disable iff (!rst_n)
    (load_w && budgeted_w && !exceed_w) |=> out_new_usage_r >= $past(amount_r))
    else $error("granted usage below requested amount");

endmodule
